>>> hdl/rfb_pkg.sv
// Shared constants, codes and controller/datapath types for the rotated 1bpp frame store.
package rfb_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 65536;
  localparam int unsigned GROUP_PIXELS    = 8;

  // Byte address arithmetic: 11-bit row times 8-bit pitch plus column byte, and room
  // to compare against the largest store size.
  localparam int unsigned CALC_W = 21;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned PITCH_W    = 8;
  localparam int unsigned USED_W     = 17;

  localparam logic [2:0] BYTE_MSB   = 3'd7;
  localparam logic [7:0] BYTE_WHITE = 8'hFF;

  localparam logic [KIND_W-1:0] KIND_DRAW_PIX = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ_PIX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW_GRP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_GRP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INVERT   = 3'd4;

  localparam logic [1:0] ORIENT_PORTRAIT     = 2'd0;
  localparam logic [1:0] ORIENT_LANDSCAPE_CW = 2'd1;
  localparam logic [1:0] ORIENT_PORTRAIT_INV = 2'd2;
  localparam logic [1:0] ORIENT_LANDSCAPE_CC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BW_MODE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESERVE_TONE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_USED    = 3'd7;

  localparam logic [1:0]        RST_ORIENTATION = ORIENT_PORTRAIT;
  localparam logic [DIM_W-1:0]  RST_PANEL_WIDTH  = 11'd800;
  localparam logic [DIM_W-1:0]  RST_PANEL_HEIGHT = 11'd480;
  localparam logic [PITCH_W-1:0] RST_ROW_BYTES   = 8'd100;
  localparam logic [USED_W-1:0] RST_FRAME_USED   = 17'd48000;

  typedef struct packed {
    logic item_load;   // latch input word, clear result
    logic loc_load;    // locate next pixel of the item
    logic rd_loc;      // read byte at located address
    logic rd_sweep;    // read byte at sweep address
    logic wr_clear;    // write white at sweep address
    logic wr_invert;   // write inverted read data at sweep address
    logic modify;      // merge/update located pixel
    logic sweep_clr;
    logic sweep_inc;
    logic out_load;    // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              n_zero;
    logic              pix_last;
    logic              inv_empty;
    logic              inv_last;
    logic              clear_last;
  } dp_stat_t;

  typedef struct packed {
    logic       read_ink;
    logic [7:0] read_pixels;
    logic       in_range;
  } result_t;

endpackage

>>> hdl/rfb_in_if.sv
// Input channel: one operation word with valid/ready.
interface rfb_in_if;
  logic                               valid;
  logic                               ready;
  logic        [rfb_pkg::KIND_W-1:0]  kind;
  logic signed [rfb_pkg::COORD_W-1:0] x;
  logic signed [rfb_pkg::COORD_W-1:0] y;
  logic                               ink;
  logic        [7:0]                  pixels;
  logic        [rfb_pkg::COUNT_W-1:0] count;

  modport source (output valid, kind, x, y, ink, pixels, count, input ready);
  modport sink   (input valid, kind, x, y, ink, pixels, count, output ready);
endinterface

>>> hdl/rfb_out_if.sv
// Output channel: one result word with valid/ready.
interface rfb_out_if;
  logic       valid;
  logic       ready;
  logic       read_ink;
  logic [7:0] read_pixels;
  logic       in_range;

  modport source (output valid, read_ink, read_pixels, in_range, input ready);
  modport sink   (input valid, read_ink, read_pixels, in_range, output ready);
endinterface

>>> hdl/rotated_1bpp_framebuffer_access.sv
// Rotated 1bpp frame store with pixel, pixel-group and invert-all access.
//
// Channels: in_ch carries one operation word (kind, x, y, ink, pixels, count), out_ch returns
// exactly one result word per operation (read_ink, read_pixels, in_range), in order. Both use
// valid/ready; a word moves at a clock edge with valid and ready high. cfg_we/cfg_idx/cfg_data
// write one configuration register per cycle; the user must write them only while no operation
// is in flight, as the block itself does not enforce this. Sequencing: one operation at a time.
// Each pixel is read, then merged and written back, on the single frame store port pair;
// invert-all reads and writes back each byte in turn. Kinds 5 to 7, empty groups and empty
// inverts go straight to the result.
// Reset: registers return to their defaults and the store is swept to white, one byte a cycle,
// over all FRAME_BYTES bytes (65536 by default); in_ch.ready stays low during that sweep.
// Stall: the result sits in an output register, so the next word is accepted while a result
// waits; a second finished result waits inside the block until out_ch.ready frees the register.
module rotated_1bpp_framebuffer_access #(
  parameter int unsigned FRAME_BYTES = rfb_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  rfb_in_if.sink                           in_ch,
  rfb_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rfb_pkg::dp_cmd_t  cmd;
  rfb_pkg::dp_stat_t stat;
  rfb_pkg::result_t  res;

  rfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfb_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (in_ch.kind),
    .in_x      (in_ch.x),
    .in_y      (in_ch.y),
    .in_ink    (in_ch.ink),
    .in_pixels (in_ch.pixels),
    .in_count  (in_ch.count),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  assign out_ch.read_ink    = res.read_ink;
  assign out_ch.read_pixels = res.read_pixels;
  assign out_ch.in_range    = res.in_range;

endmodule

>>> hdl/rfb_ctrl.sv
// Sequencing state machine: clear pass, per-pixel read-modify-write, invert sweep, result hand-off.
module rfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  rfb_pkg::dp_stat_t stat,
  output rfb_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_START  = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_MODIFY = 8'b0001_0000,
    S_INV_RD = 8'b0010_0000,
    S_INV_WR = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_clear  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        // first pixel is located here whatever the kind; harmless otherwise
        cmd.loc_load  = 1'b1;
        cmd.sweep_clr = 1'b1;
        unique case (stat.kind)
          rfb_pkg::KIND_DRAW_PIX, rfb_pkg::KIND_READ_PIX,
          rfb_pkg::KIND_DRAW_GRP, rfb_pkg::KIND_READ_GRP: begin
            state_next = stat.n_zero ? S_FINISH : S_READ;
          end
          rfb_pkg::KIND_INVERT: begin
            state_next = stat.inv_empty ? S_FINISH : S_INV_RD;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_READ: begin
        cmd.rd_loc = 1'b1;
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        if (stat.pix_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.loc_load = 1'b1;
          state_next   = S_READ;
        end
      end
      S_INV_RD: begin
        cmd.rd_sweep = 1'b1;
        state_next   = S_INV_WR;
      end
      S_INV_WR: begin
        cmd.wr_invert = 1'b1;
        if (stat.inv_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.sweep_inc = 1'b1;
          state_next    = S_INV_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/rfb_dp.sv
// Datapath: registers, coordinate rotation and addressing, frame store memory, result build.
module rfb_dp #(
  parameter int unsigned FRAME_BYTES = rfb_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rfb_pkg::dp_cmd_t                    cmd,
  output rfb_pkg::dp_stat_t                   stat,
  input  logic        [rfb_pkg::KIND_W-1:0]   in_kind,
  input  logic signed [rfb_pkg::COORD_W-1:0]  in_x,
  input  logic signed [rfb_pkg::COORD_W-1:0]  in_y,
  input  logic                                in_ink,
  input  logic        [7:0]                   in_pixels,
  input  logic        [rfb_pkg::COUNT_W-1:0]  in_count,
  input  logic                                cfg_we,
  input  logic        [rfb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic        [rfb_pkg::CFG_DATA_W-1:0] cfg_data,
  output rfb_pkg::result_t                    res
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = rfb_pkg::CALC_W;
  localparam logic [CW-1:0] FB_LIM    = CW'(FRAME_BYTES);
  localparam logic [AW-1:0] SWEEP_END = AW'(FRAME_BYTES - 1);

  // configuration
  logic [1:0]                       orientation;
  logic [rfb_pkg::DIM_W-1:0]        panel_width;
  logic [rfb_pkg::DIM_W-1:0]        panel_height;
  logic [rfb_pkg::PITCH_W-1:0]      row_bytes;
  logic                             dark_mode;
  logic                             bw_mode;
  logic                             preserve_tone;
  logic [rfb_pkg::USED_W-1:0]       frame_bytes_used;

  // current item
  logic        [rfb_pkg::KIND_W-1:0]  kind;
  logic signed [rfb_pkg::COORD_W-1:0] item_x;
  logic signed [rfb_pkg::COORD_W-1:0] item_y;
  logic                               item_ink;
  logic        [7:0]                  item_pixels;
  logic        [rfb_pkg::COUNT_W-1:0] item_n;
  logic        [rfb_pkg::COUNT_W-1:0] n_next;
  logic        [rfb_pkg::COUNT_W-1:0] idx;

  // located pixel
  logic          loc_on;
  logic          loc_st;
  logic [AW-1:0] loc_addr;
  logic [2:0]    loc_bit;
  logic [2:0]    loc_pos;

  logic [AW-1:0] sweep;

  // result accumulators
  logic       acc_ink;
  logic [7:0] acc_pix;
  logic       acc_hit;

  // memory
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  // rotation / addressing
  logic signed [12:0] lx;
  logic signed [13:0] sx, sy, sw, sh, px, py;
  logic               on_panel;
  logic [18:0]        row_off;
  logic [CW-1:0]      byte_addr;
  logic               is_single;
  logic               is_draw;
  logic               dark_inv;
  logic               pix_inked;
  logic               bit_ink;
  logic [7:0]         merged;
  logic [CW-1:0]      inv_len;
  logic [CW-1:0]      used_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation      <= rfb_pkg::RST_ORIENTATION;
      panel_width      <= rfb_pkg::RST_PANEL_WIDTH;
      panel_height     <= rfb_pkg::RST_PANEL_HEIGHT;
      row_bytes        <= rfb_pkg::RST_ROW_BYTES;
      dark_mode        <= 1'b0;
      bw_mode          <= 1'b1;
      preserve_tone    <= 1'b0;
      frame_bytes_used <= rfb_pkg::RST_FRAME_USED;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rfb_pkg::CFG_ORIENTATION:   orientation      <= cfg_data[1:0];
        rfb_pkg::CFG_PANEL_WIDTH:   panel_width      <= cfg_data[rfb_pkg::DIM_W-1:0];
        rfb_pkg::CFG_PANEL_HEIGHT:  panel_height     <= cfg_data[rfb_pkg::DIM_W-1:0];
        rfb_pkg::CFG_ROW_BYTES:     row_bytes        <= cfg_data[rfb_pkg::PITCH_W-1:0];
        rfb_pkg::CFG_DARK_MODE:     dark_mode        <= cfg_data[0];
        rfb_pkg::CFG_BW_MODE:       bw_mode          <= cfg_data[0];
        rfb_pkg::CFG_PRESERVE_TONE: preserve_tone    <= cfg_data[0];
        rfb_pkg::CFG_FRAME_USED:    frame_bytes_used <= cfg_data[rfb_pkg::USED_W-1:0];
        default: ;
      endcase
    end
  end

  // single-pixel kinds act on exactly one pixel; groups clamp to eight
  always_comb begin
    if (in_kind == rfb_pkg::KIND_DRAW_PIX || in_kind == rfb_pkg::KIND_READ_PIX) begin
      n_next = rfb_pkg::COUNT_W'(1);
    end else if (in_count > rfb_pkg::COUNT_W'(rfb_pkg::GROUP_PIXELS)) begin
      n_next = rfb_pkg::COUNT_W'(rfb_pkg::GROUP_PIXELS);
    end else begin
      n_next = in_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      kind        <= in_kind;
      item_x      <= in_x;
      item_y      <= in_y;
      item_ink    <= in_ink;
      item_pixels <= in_pixels;
      item_n      <= n_next;
    end
  end

  always_comb begin
    lx = 13'(item_x) + 13'(idx);
    sx = 14'(lx);
    sy = 14'(item_y);
    sw = 14'(panel_width);
    sh = 14'(panel_height);
    unique case (orientation)
      rfb_pkg::ORIENT_PORTRAIT: begin
        px = sy;
        py = sh - 14'sd1 - sx;
      end
      rfb_pkg::ORIENT_LANDSCAPE_CW: begin
        px = sw - 14'sd1 - sx;
        py = sh - 14'sd1 - sy;
      end
      rfb_pkg::ORIENT_PORTRAIT_INV: begin
        px = sw - 14'sd1 - sy;
        py = sx;
      end
      default: begin
        px = sx;
        py = sy;
      end
    endcase
    on_panel  = !px[13] && (px < sw) && !py[13] && (py < sh);
    row_off   = 19'(py[10:0]) * 19'(row_bytes);
    byte_addr = CW'(row_off) + CW'(px[10:3]);
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      idx <= '0;
    end else if (cmd.loc_load) begin
      idx <= idx + rfb_pkg::COUNT_W'(1);
    end
    if (cmd.loc_load) begin
      loc_on   <= on_panel;
      loc_st   <= on_panel && (byte_addr < FB_LIM);
      loc_addr <= byte_addr[AW-1:0];
      loc_bit  <= rfb_pkg::BYTE_MSB - px[2:0];
      loc_pos  <= idx[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_inc) begin
      sweep <= sweep + AW'(1);
    end
  end

  // pixel merge; a 0 bit is ink
  always_comb begin
    is_single = (kind == rfb_pkg::KIND_DRAW_PIX) || (kind == rfb_pkg::KIND_READ_PIX);
    is_draw   = (kind == rfb_pkg::KIND_DRAW_PIX) || (kind == rfb_pkg::KIND_DRAW_GRP);
    dark_inv  = dark_mode && bw_mode && !preserve_tone;
    if (kind == rfb_pkg::KIND_DRAW_PIX) begin
      pix_inked = item_ink ^ dark_inv;
    end else begin
      pix_inked = item_pixels[rfb_pkg::BYTE_MSB - loc_pos];
    end
    bit_ink          = loc_st && !mem_rdata[loc_bit];
    merged           = mem_rdata;
    merged[loc_bit]  = !pix_inked;
  end

  always_comb begin
    mem_re    = cmd.rd_loc || cmd.rd_sweep;
    mem_raddr = cmd.rd_sweep ? sweep : loc_addr;
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = rfb_pkg::BYTE_WHITE;
    if (cmd.wr_clear) begin
      mem_we = 1'b1;
    end else if (cmd.wr_invert) begin
      mem_we    = 1'b1;
      mem_wdata = ~mem_rdata;
    end else if (cmd.modify && loc_st && is_draw) begin
      mem_we    = 1'b1;
      mem_waddr = loc_addr;
      mem_wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      acc_ink <= 1'b0;
      acc_pix <= '0;
      acc_hit <= 1'b0;
    end else if (cmd.modify) begin
      if (is_single) begin
        acc_hit <= loc_on;
      end
      if (kind == rfb_pkg::KIND_READ_PIX) begin
        acc_ink <= bit_ink;
      end
      if (kind == rfb_pkg::KIND_READ_GRP && bit_ink) begin
        acc_pix[rfb_pkg::BYTE_MSB - loc_pos] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.read_ink    <= acc_ink;
      res.read_pixels <= acc_pix;
      res.in_range    <= acc_hit;
    end
  end

  always_comb begin
    used_ext        = CW'(frame_bytes_used);
    inv_len         = (used_ext > FB_LIM) ? FB_LIM : used_ext;
    stat.kind       = kind;
    stat.n_zero     = (item_n == '0);
    stat.pix_last   = (idx == item_n);
    stat.inv_empty  = (frame_bytes_used == '0);
    stat.inv_last   = ((CW'(sweep) + CW'(1)) == inv_len);
    stat.clear_last = (sweep == SWEEP_END);
  end

endmodule

>>> hdl/rfb_check.sv
// Port-level checks for the rotated 1bpp frame store, bound to the top level.
module rfb_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       read_ink,
  input logic [7:0] read_pixels,
  input logic       in_range
);

  // result word held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_ink) && $stable(read_pixels) && $stable(in_range))
    else $error("result word changed while stalled");

  // store clear pass blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input accepted during clear pass");

  // one operation at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted back to back");

  // ink can only be read from a pixel on the panel, and only one read field is live
  a_ink_on_panel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!read_ink || in_range) && !(read_ink && (read_pixels != 8'd0)))
    else $error("inconsistent read result");

endmodule

bind rotated_1bpp_framebuffer_access rfb_check u_rfb_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_ink    (out_ch.read_ink),
  .read_pixels (out_ch.read_pixels),
  .in_range    (out_ch.in_range)
);

>>> verif/rotated_1bpp_framebuffer_access_tb.sv
// Self-checking testbench for the rotated 1bpp frame store against a shadow store.
module rotated_1bpp_framebuffer_access_tb;

  localparam int FB_BYTES    = rfb_pkg::FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_OPS   = 156;
  localparam int HOLD_CYCLES = 400;
  localparam logic [rfb_pkg::KIND_W-1:0] KIND_SPARE = rfb_pkg::KIND_INVERT + 3'd1;

  typedef struct packed {
    logic [rfb_pkg::KIND_W-1:0]         kind;
    logic signed [rfb_pkg::COORD_W-1:0] x;
    logic signed [rfb_pkg::COORD_W-1:0] y;
    logic                               ink;
    logic [7:0]                         pixels;
    logic [rfb_pkg::COUNT_W-1:0]        count;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we;
  logic [rfb_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [rfb_pkg::CFG_DATA_W-1:0] cfg_data;

  rfb_in_if  in_ch();
  rfb_out_if out_ch();

  rotated_1bpp_framebuffer_access u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the frame store and of the register file
  logic [7:0]                  shadow_store [FB_BYTES];
  logic [1:0]                  orient_r;
  logic [rfb_pkg::DIM_W-1:0]   width_r;
  logic [rfb_pkg::DIM_W-1:0]   height_r;
  logic [rfb_pkg::PITCH_W-1:0] pitch_r;
  logic                        dark_r;
  logic                        bw_r;
  logic                        tone_r;
  logic [rfb_pkg::USED_W-1:0]  used_r;

  op_t              pending_ops[$];
  rfb_pkg::result_t expected_results[$];
  op_t              drv_op;
  rfb_pkg::result_t want;

  int unsigned ops_offered;
  int unsigned ops_accepted;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned inverts_seen;
  int unsigned settings_used;
  int unsigned cycle_cnt;
  int          in_gap;
  int          stall_left;
  int          hold_left;
  bit          gap_on;
  bit          stall_on;
  bit          hold_phase;
  bit          hold_done;

  // logical window that random traffic concentrates on
  int win_x, win_y, span_x, span_y;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // rotate logical (lx, ly) onto the panel; returns 1 on a panel hit
  function automatic bit locate(input int lx, input int ly, output int addr,
                                output logic [7:0] mask);
    int w, h, px, py;
    w = int'(width_r);
    h = int'(height_r);
    addr = 0;
    mask = '0;
    case (orient_r)
      rfb_pkg::ORIENT_PORTRAIT:     begin px = ly;         py = h - 1 - lx; end
      rfb_pkg::ORIENT_LANDSCAPE_CW: begin px = w - 1 - lx; py = h - 1 - ly; end
      rfb_pkg::ORIENT_PORTRAIT_INV: begin px = w - 1 - ly; py = lx;         end
      default:                      begin px = lx;         py = ly;         end
    endcase
    if (px < 0 || px >= w || py < 0 || py >= h) return 0;
    addr = py * int'(pitch_r) + px / 8;
    mask = 8'h80 >> (px & 7);
    return 1;
  endfunction

  function automatic void paint(input int addr, input logic [7:0] mask, input logic inked);
    if (inked) shadow_store[addr] = shadow_store[addr] & ~mask;
    else       shadow_store[addr] = shadow_store[addr] | mask;
  endfunction

  function automatic rfb_pkg::result_t predict_access(
      input logic [rfb_pkg::KIND_W-1:0] kind, input int x, input int y, input logic ink,
      input logic [7:0] pixels, input logic [rfb_pkg::COUNT_W-1:0] count);
    rfb_pkg::result_t r;
    int               n, span, addr, i;
    logic [7:0]       mask;
    r = '0;
    n = (int'(count) > int'(rfb_pkg::GROUP_PIXELS)) ? int'(rfb_pkg::GROUP_PIXELS)
                                                    : int'(count);
    case (kind)
      rfb_pkg::KIND_DRAW_PIX: begin
        if (locate(x, y, addr, mask)) begin
          r.in_range = 1'b1;
          if (addr < FB_BYTES) paint(addr, mask, ink ^ (dark_r & bw_r & ~tone_r));
        end
      end
      rfb_pkg::KIND_READ_PIX: begin
        if (locate(x, y, addr, mask)) begin
          r.in_range = 1'b1;
          if (addr < FB_BYTES && (shadow_store[addr] & mask) == 8'h00) r.read_ink = 1'b1;
        end
      end
      rfb_pkg::KIND_DRAW_GRP: begin
        for (i = 0; i < n; i++)
          if (locate(x + i, y, addr, mask) && addr < FB_BYTES)
            paint(addr, mask, pixels[7 - i]);
      end
      rfb_pkg::KIND_READ_GRP: begin
        for (i = 0; i < n; i++)
          if (locate(x + i, y, addr, mask) && addr < FB_BYTES &&
              (shadow_store[addr] & mask) == 8'h00)
            r.read_pixels[7 - i] = 1'b1;
      end
      rfb_pkg::KIND_INVERT: begin
        span = (int'(used_r) > FB_BYTES) ? FB_BYTES : int'(used_r);
        for (i = 0; i < span; i++) shadow_store[i] = ~shadow_store[i];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic set_reg(input logic [rfb_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[rfb_pkg::CFG_DATA_W-1:0];
    case (idx)
      rfb_pkg::CFG_ORIENTATION:   orient_r = value[1:0];
      rfb_pkg::CFG_PANEL_WIDTH:   width_r  = value[rfb_pkg::DIM_W-1:0];
      rfb_pkg::CFG_PANEL_HEIGHT:  height_r = value[rfb_pkg::DIM_W-1:0];
      rfb_pkg::CFG_ROW_BYTES:     pitch_r  = value[rfb_pkg::PITCH_W-1:0];
      rfb_pkg::CFG_DARK_MODE:     dark_r   = value[0];
      rfb_pkg::CFG_BW_MODE:       bw_r     = value[0];
      rfb_pkg::CFG_PRESERVE_TONE: tone_r   = value[0];
      rfb_pkg::CFG_FRAME_USED:    used_r   = value[rfb_pkg::USED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input int unsigned o, input int unsigned w, input int unsigned h,
                         input int unsigned rb, input int unsigned d, input int unsigned b,
                         input int unsigned t, input int unsigned u);
    set_reg(rfb_pkg::CFG_ORIENTATION, o);
    set_reg(rfb_pkg::CFG_PANEL_WIDTH, w);
    set_reg(rfb_pkg::CFG_PANEL_HEIGHT, h);
    set_reg(rfb_pkg::CFG_ROW_BYTES, rb);
    set_reg(rfb_pkg::CFG_DARK_MODE, d);
    set_reg(rfb_pkg::CFG_BW_MODE, b);
    set_reg(rfb_pkg::CFG_PRESERVE_TONE, t);
    set_reg(rfb_pkg::CFG_FRAME_USED, u);
    settings_used++;
  endtask

  task automatic push_op(input logic [rfb_pkg::KIND_W-1:0] kind, input int x, input int y,
                         input logic ink, input logic [7:0] pixels, input int count);
    op_t op;
    op.kind   = kind;
    op.x      = x[rfb_pkg::COORD_W-1:0];
    op.y      = y[rfb_pkg::COORD_W-1:0];
    op.ink    = ink;
    op.pixels = pixels;
    op.count  = count[rfb_pkg::COUNT_W-1:0];
    pending_ops.push_back(op);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || ops_offered != ops_accepted ||
           expected_results.size() != 0)
      @(posedge clk);
  endtask

  // new window anchor inside the logical extent
  task automatic move_window();
    win_x = $urandom_range(0, span_x - 1);
    win_y = $urandom_range(0, span_y - 1);
  endtask

  task automatic push_random_op();
    logic [rfb_pkg::KIND_W-1:0] kind;
    int r, c, x, y, cnt;
    r = $urandom_range(0, 99);
    if (r < 24)      kind = rfb_pkg::KIND_DRAW_PIX;
    else if (r < 48) kind = rfb_pkg::KIND_READ_PIX;
    else if (r < 68) kind = rfb_pkg::KIND_DRAW_GRP;
    else if (r < 90) kind = rfb_pkg::KIND_READ_GRP;
    else if (r < 95) kind = rfb_pkg::KIND_INVERT;
    else             kind = rfb_pkg::KIND_W'(KIND_SPARE + $urandom_range(0, 2));
    c = $urandom_range(0, 99);
    if (c < 75) begin
      x = win_x + $urandom_range(0, 23) - 6;
      y = win_y + $urandom_range(0, 15) - 4;
    end else if (c < 90) begin
      x = $urandom_range(0, span_x - 1);
      y = $urandom_range(0, span_y - 1);
    end else begin
      x = $urandom;
      y = $urandom;
    end
    c = $urandom_range(0, 9);
    if (c == 0)      cnt = 0;
    else if (c == 1) cnt = $urandom_range(9, 15);
    else             cnt = $urandom_range(1, 8);
    push_op(kind, x, y, 1'($urandom_range(0, 1)), 8'($urandom), cnt);
  endtask

  // input side: one word offered at a time, random gaps between words while gap_on is set
  always @(negedge clk) begin
    if (!rst && ops_accepted == ops_offered) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_ops.size() != 0) begin
        drv_op = pending_ops.pop_front();
        in_ch.kind   <= drv_op.kind;
        in_ch.x      <= drv_op.x;
        in_ch.y      <= drv_op.y;
        in_ch.ink    <= drv_op.ink;
        in_ch.pixels <= drv_op.pixels;
        in_ch.count  <= drv_op.count;
        in_ch.valid  <= 1'b1;
        ops_offered++;
        in_gap = gap_on ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output side: random stalls while stall_on is set, plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_phase && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = stall_on ? pick_gap() : 0;
      end
    end
  end

  // monitor: predict on accepted words, check accepted results in order
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result word with no operation pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_ink !== want.read_ink) begin
            $error("read_ink: expected %0b, got %0b", want.read_ink, out_ch.read_ink);
            mismatches++;
          end
          if (out_ch.read_pixels !== want.read_pixels) begin
            $error("read_pixels: expected %02h, got %02h", want.read_pixels,
                   out_ch.read_pixels);
            mismatches++;
          end
          if (out_ch.in_range !== want.in_range) begin
            $error("in_range: expected %0b, got %0b", want.in_range, out_ch.in_range);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == rfb_pkg::KIND_INVERT) inverts_seen++;
        expected_results.push_back(predict_access(in_ch.kind, in_ch.x, in_ch.y, in_ch.ink,
                                                  in_ch.pixels, in_ch.count));
        ops_accepted++;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
             expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.kind   = rfb_pkg::KIND_DRAW_PIX;
    in_ch.x      = '0;
    in_ch.y      = '0;
    in_ch.ink    = 1'b0;
    in_ch.pixels = '0;
    in_ch.count  = '0;
    out_ch.ready = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = rfb_pkg::CFG_ORIENTATION;
    cfg_data = '0;
    for (int i = 0; i < FB_BYTES; i++) shadow_store[i] = rfb_pkg::BYTE_WHITE;
    orient_r = rfb_pkg::RST_ORIENTATION;
    width_r  = rfb_pkg::RST_PANEL_WIDTH;
    height_r = rfb_pkg::RST_PANEL_HEIGHT;
    pitch_r  = rfb_pkg::RST_ROW_BYTES;
    dark_r   = 1'b0;
    bw_r     = 1'b1;
    tone_r   = 1'b0;
    used_r   = rfb_pkg::RST_FRAME_USED;
    gap_on   = 1'b1;
    stall_on = 1'b1;
    hold_phase = 1'b0;
    hold_done  = 1'b0;
    in_gap = 0;
    stall_left = 0;
    hold_left = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // store is swept to white before the input opens
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    // reset settings, portrait 800x480
    push_op(rfb_pkg::KIND_DRAW_PIX, 0, 0, 1'b1, 8'h00, 1);
    push_op(rfb_pkg::KIND_READ_PIX, 0, 0, 1'b0, 8'h00, 1);
    push_op(rfb_pkg::KIND_DRAW_PIX, -2048, 2047, 1'b1, 8'hFF, 15);
    push_op(rfb_pkg::KIND_READ_PIX, 2047, -2048, 1'b1, 8'hFF, 15);
    push_op(rfb_pkg::KIND_DRAW_GRP, 0, 8, 1'b0, 8'hA5, 8);
    push_op(rfb_pkg::KIND_READ_GRP, 0, 8, 1'b0, 8'h00, 8);
    push_op(rfb_pkg::KIND_DRAW_GRP, 0, 8, 1'b0, 8'hFF, 0);
    push_op(rfb_pkg::KIND_READ_GRP, 0, 8, 1'b0, 8'h00, 0);
    push_op(rfb_pkg::KIND_DRAW_GRP, 474, 8, 1'b0, 8'hFF, 15);
    push_op(rfb_pkg::KIND_READ_GRP, 472, 8, 1'b0, 8'h00, 8);
    push_op(rfb_pkg::KIND_INVERT, 0, 0, 1'b0, 8'h00, 0);
    push_op(rfb_pkg::KIND_READ_GRP, 0, 8, 1'b0, 8'h00, 8);
    push_op(KIND_SPARE, -1, -1, 1'b1, 8'hFF, 15);
    wait_idle();

    // dark inversion only with bw on and tone preservation off
    set_reg(rfb_pkg::CFG_DARK_MODE, 1);
    push_op(rfb_pkg::KIND_DRAW_PIX, 3, 3, 1'b1, 8'h00, 1);
    push_op(rfb_pkg::KIND_READ_PIX, 3, 3, 1'b0, 8'h00, 1);
    wait_idle();
    set_reg(rfb_pkg::CFG_PRESERVE_TONE, 1);
    push_op(rfb_pkg::KIND_DRAW_PIX, 3, 3, 1'b1, 8'h00, 1);
    push_op(rfb_pkg::KIND_READ_PIX, 3, 3, 1'b0, 8'h00, 1);
    wait_idle();
    set_reg(rfb_pkg::CFG_PRESERVE_TONE, 0);
    set_reg(rfb_pkg::CFG_BW_MODE, 0);
    push_op(rfb_pkg::KIND_DRAW_PIX, 4, 3, 1'b1, 8'h00, 1);
    push_op(rfb_pkg::KIND_READ_PIX, 4, 3, 1'b0, 8'h00, 1);
    wait_idle();

    // top of the store: last byte and one row past it, full-store inverts, then an empty invert
    set_all(rfb_pkg::ORIENT_LANDSCAPE_CC, 1024, 1024, 64, 0, 1, 0, 131071);
    push_op(rfb_pkg::KIND_DRAW_PIX, 1023, 1022, 1'b1, 8'h00, 1);
    push_op(rfb_pkg::KIND_DRAW_PIX, 1023, 1023, 1'b1, 8'h00, 1);
    push_op(rfb_pkg::KIND_READ_PIX, 1023, 1023, 1'b0, 8'h00, 1);
    push_op(rfb_pkg::KIND_INVERT, 0, 0, 1'b0, 8'h00, 0);
    push_op(rfb_pkg::KIND_READ_PIX, 1023, 1022, 1'b0, 8'h00, 1);
    wait_idle();
    set_reg(rfb_pkg::CFG_FRAME_USED, FB_BYTES);
    push_op(rfb_pkg::KIND_INVERT, 0, 0, 1'b0, 8'h00, 0);
    wait_idle();
    set_reg(rfb_pkg::CFG_FRAME_USED, 0);
    set_reg(rfb_pkg::CFG_PANEL_WIDTH, 0);
    push_op(rfb_pkg::KIND_INVERT, 0, 0, 1'b0, 8'h00, 0);
    push_op(rfb_pkg::KIND_READ_PIX, 0, 0, 1'b0, 8'h00, 1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      int sel, w, h, rb;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 48);
      end else if (sel < 8) begin
        w = $urandom_range(1, 1024);
        h = $urandom_range(1, 1024);
      end else if (sel == 8) begin
        w = 1;
        h = 1024;
      end else begin
        w = 2047;
        h = $urandom_range(1, 2047);
      end
      rb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : (w + 7) / 8;
      if (rb > 255) rb = 255;
      set_all(p % 4, w, h, rb, $urandom_range(0, 1), $urandom_range(0, 1),
              $urandom_range(0, 1), $urandom_range(0, 600));
      if (orient_r == rfb_pkg::ORIENT_PORTRAIT || orient_r == rfb_pkg::ORIENT_PORTRAIT_INV)
      begin
        span_x = h;
        span_y = w;
      end else begin
        span_x = w;
        span_y = h;
      end
      gap_on   = (p != 1 && p != 3);
      stall_on = (p != 1);
      for (int i = 0; i < PHASE_OPS; i++) begin
        if (i % 40 == 0) move_window();
        push_random_op();
      end
      // receiver holds off while the sender keeps the input full
      if (p == 3) hold_phase = 1'b1;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d operations in %0d register settings, %0d results checked, %0d inverts",
             ops_accepted, settings_used, results_checked, inverts_seen);
    $display("all four orientations, off-panel and past-store pixels, dark mode gating");
    if (mismatches == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
